// ===== hw/rtl/nlc_pkg.sv =====
// Package for the numeric literal classifier.
// Holds the character codes, scan mode and class encodings, and the scan state record.
// No dependencies; imported by every file but nlc_if.
package nlc_pkg;

   localparam int CHAR_W = 8;
   localparam int POS_W  = 2;

   localparam logic [POS_W-1:0] POS_MAX    = 2'd3;
   localparam logic [POS_W-1:0] POS_PREFIX = 2'd1;

   // ASCII codes the scanner recognises
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;  // '1'
   localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;  // '7'
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;  // 'E'
   localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;  // 'F'
   localparam logic [CHAR_W-1:0] CH_UP_P  = 8'h50;  // 'P'
   localparam logic [CHAR_W-1:0] CH_LO_B  = 8'h62;  // 'b'
   localparam logic [CHAR_W-1:0] CH_LO_E  = 8'h65;  // 'e'
   localparam logic [CHAR_W-1:0] CH_LO_P  = 8'h70;  // 'p'
   localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;  // 'x'
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
   localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;  // '_'

   // Scan mode, one-hot
   typedef enum logic [5:0] {
      MODE_START = 6'b000001,
      MODE_ZERO  = 6'b000010,
      MODE_DEC   = 6'b000100,
      MODE_HEX   = 6'b001000,
      MODE_BIN   = 6'b010000,
      MODE_OCT   = 6'b100000
   } mode_type;

   // Literal class reported at the end of a word
   typedef enum logic [2:0] {
      CLASS_INVALID    = 3'd0,
      CLASS_INT        = 3'd1,
      CLASS_DOUBLE     = 3'd2,
      CLASS_HEX_INT    = 3'd3,
      CLASS_HEX_DOUBLE = 3'd4,
      CLASS_BINARY     = 3'd5,
      CLASS_OCTAL      = 3'd6
   } class_type;

   // Per-word scan state
   typedef struct packed {
      logic [POS_W-1:0]  position;
      mode_type          mode;
      logic [CHAR_W-1:0] prev_char;
      logic              exp_seen;
      logic              dot_seen;
      logic              sign_ok;
      logic              rejected;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      position:  '0,
      mode:      MODE_START,
      prev_char: '0,
      exp_seen:  1'b0,
      dot_seen:  1'b0,
      sign_ok:   1'b0,
      rejected:  1'b0
   };

endpackage

// ===== hw/rtl/nlc_if.sv =====
// Valid/ready channel interfaces for the numeric literal classifier.
// nlc_req_if carries one character per transaction, nlc_rsp_if one literal class.
// Depends on nothing; widths match nlc_pkg.
interface nlc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface nlc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] literal_class;

   modport source (output valid, output literal_class, input ready);
   modport sink   (input valid, input literal_class, output ready);
endinterface

// ===== hw/rtl/nlc_scan.sv =====
// Combinational character step of the numeric literal classifier.
// Takes the scan state and one character, gives the next state and the word's class.
// Depends on nlc_pkg.
module nlc_scan
   import nlc_pkg::*;
(
   input  scan_state_type    state,
   input  logic [CHAR_W-1:0] char_code,
   input  logic              last_char,
   output scan_state_type    state_next,
   output class_type         lit_class
);

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_octal(input logic [CHAR_W-1:0] c);
      return (c >= CH_ZERO) && (c <= CH_SEVEN);
   endfunction

   function automatic logic is_sign(input logic [CHAR_W-1:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

   // Decimal body: underscore skip, sign window, exponent, dot, digits
   function automatic scan_state_type take_decimal(input scan_state_type s,
                                                   input logic [CHAR_W-1:0] c);
      scan_state_type r;
      r = s;
      if (c == CH_UNDER) begin
         r = s;
      end else if (s.sign_ok && is_sign(c)) begin
         r.sign_ok = 1'b0;
      end else begin
         r.sign_ok = 1'b0;
         if (c == CH_LO_E || c == CH_UP_E) begin
            if (s.exp_seen || s.prev_char == CH_DOT) begin
               r.rejected = 1'b1;
            end else begin
               r.sign_ok  = 1'b1;
               r.dot_seen = 1'b1;
               r.exp_seen = 1'b1;
            end
         end else if (c == CH_DOT) begin
            if (s.dot_seen || s.exp_seen) r.rejected = 1'b1;
            else r.dot_seen = 1'b1;
         end else if (!is_digit(c)) begin
            r.rejected = 1'b1;
         end
      end
      return r;
   endfunction

   // Hex body: sign window, p/P exponent, one dot, upper-case hex digits
   function automatic scan_state_type take_hex(input scan_state_type s,
                                               input logic [CHAR_W-1:0] c);
      scan_state_type r;
      logic past_prefix;
      r = s;
      past_prefix = (s.position == POS_MAX);
      if (s.sign_ok && is_sign(c)) begin
         r.sign_ok = 1'b0;
      end else begin
         r.sign_ok = 1'b0;
         if (past_prefix && (c == CH_LO_P || c == CH_UP_P) && !s.exp_seen &&
             s.prev_char != CH_DOT) begin
            r.exp_seen = 1'b1;
            r.dot_seen = 1'b1;
            r.sign_ok  = 1'b1;
         end else if (past_prefix && c == CH_DOT && !s.dot_seen) begin
            r.dot_seen = 1'b1;
         end else if (c != CH_UNDER && !(c >= CH_UP_A && c <= CH_UP_F) && !is_digit(c)) begin
            r.rejected = 1'b1;
         end
      end
      return r;
   endfunction

   scan_state_type taken;

   // Apply the character to the state unless the word is already rejected
   always_comb begin
      taken = state;
      if (!state.rejected) begin
         case (state.mode)
            MODE_START: begin
               if (!is_digit(char_code)) taken.rejected = 1'b1;
               else if (char_code == CH_ZERO) taken.mode = MODE_ZERO;
               else taken.mode = MODE_DEC;
            end
            MODE_ZERO: begin
               if (char_code == CH_DOT) begin
                  taken.mode     = MODE_DEC;
                  taken.dot_seen = 1'b1;
                  taken.sign_ok  = 1'b0;
               end else if (char_code == CH_LO_X) begin
                  taken.mode = MODE_HEX;
               end else if (char_code == CH_LO_B) begin
                  taken.mode = MODE_BIN;
               end else begin
                  taken.mode = MODE_OCT;
                  if (char_code != CH_UNDER && !is_octal(char_code)) taken.rejected = 1'b1;
               end
            end
            MODE_DEC: taken = take_decimal(state, char_code);
            MODE_HEX: taken = take_hex(state, char_code);
            MODE_BIN: begin
               if (char_code != CH_UNDER && char_code != CH_ZERO && char_code != CH_ONE)
                  taken.rejected = 1'b1;
            end
            MODE_OCT: begin
               if (char_code != CH_UNDER && !is_octal(char_code)) taken.rejected = 1'b1;
            end
            default: taken.rejected = 1'b1;
         endcase
      end
   end

   // Classify the word as it stands after this character
   always_comb begin
      lit_class = CLASS_INVALID;
      if (!taken.rejected) begin
         case (taken.mode)
            MODE_ZERO: lit_class = CLASS_INT;
            MODE_DEC: begin
               if (!is_digit(char_code) && char_code != CH_UNDER) lit_class = CLASS_INVALID;
               else if (taken.dot_seen) lit_class = CLASS_DOUBLE;
               else lit_class = CLASS_INT;
            end
            MODE_HEX: begin
               if (state.position == POS_PREFIX) lit_class = CLASS_INVALID;
               else if (taken.dot_seen && !taken.exp_seen) lit_class = CLASS_INVALID;
               else if (taken.dot_seen) lit_class = CLASS_HEX_DOUBLE;
               else lit_class = CLASS_HEX_INT;
            end
            MODE_BIN: begin
               if (state.position == POS_PREFIX) lit_class = CLASS_INVALID;
               else lit_class = CLASS_BINARY;
            end
            MODE_OCT: lit_class = CLASS_OCTAL;
            default:  lit_class = CLASS_INVALID;
         endcase
      end
   end

   // Clear on the final character, otherwise record it and advance the position
   always_comb begin
      if (last_char) begin
         state_next = SCAN_RESET;
      end else begin
         state_next           = taken;
         state_next.prev_char = char_code;
         state_next.position  = (state.position == POS_MAX) ? POS_MAX
                                                              : state.position + POS_PREFIX;
      end
   end

endmodule

// ===== hw/rtl/nlc_rsp_reg.sv =====
// Result register of the numeric literal classifier.
// Holds one literal class until the receiver takes it; reports when it can load.
// Depends on nlc_pkg and nlc_if.
module nlc_rsp_reg
   import nlc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  class_type         lit_class,
   output logic              can_load,
   nlc_rsp_if.source         rsp_if
);

   logic      valid_ff, valid_in;
   class_type class_ff, class_in;

   // Free when empty or when the held transaction leaves this cycle
   assign can_load = !valid_ff || rsp_if.ready;

   // Load a new class, drop a taken one, hold otherwise
   always_comb begin
      valid_in = valid_ff;
      class_in = class_ff;
      if (load) begin
         valid_in = 1'b1;
         class_in = lit_class;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.literal_class = class_ff;

endmodule

// ===== hw/rtl/numeric_literal_classifier_core.sv =====
// Numeric literal classifier, top level.
// Holds the input register, the scan state register and the result register.
// Depends on nlc_pkg, nlc_if, nlc_scan and nlc_rsp_reg.
//
// Usage:
//   req_if carries one character of a word per transaction (char_code), with
//   last_char set on the word's final character. rsp_if carries one literal
//   class per word (0 invalid, 1 int, 2 double, 3 hex int, 4 hex double,
//   5 binary, 6 octal), only for the final character.
//   A character is held in the input register, then the scan logic updates
//   the word state; the class of a final character is loaded into the result
//   register when it has room and is then valid on rsp_if.
//   One character per cycle is taken unless a final character waits for the
//   result register; the state update from the input register is combinational.
//   A stalled rsp_if holds the class; characters that produce no class keep
//   flowing, and a second final character waits in the input register until
//   the result register frees.
//   Synchronous reset empties both registers and clears the word state; no
//   clearing pass is needed, req_if.ready is high once reset clears the input register.
module numeric_literal_classifier_core
   import nlc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   nlc_req_if.sink   req_if,
   nlc_rsp_if.source rsp_if
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff, in_char_in;
   logic              in_last_ff, in_last_in;
   scan_state_type    state_ff, state_in, state_next;
   class_type         lit_class;
   logic              rsp_can_load;
   logic              advance;
   logic              req_accept;

   // Move the held character through the scan; a final character waits for room in the result
   assign advance    = in_valid_ff && (!in_last_ff || rsp_can_load);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_accept = req_if.valid && req_if.ready;

   // Input register: load on a transaction, hold while stalled
   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      in_char_in  = in_char_ff;
      in_last_in  = in_last_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_char_in  = req_if.char_code;
         in_last_in  = req_if.last_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      in_last_ff <= in_last_in;
   end

   nlc_scan u_scan (
      .state      (state_ff),
      .char_code  (in_char_ff),
      .last_char  (in_last_ff),
      .state_next (state_next),
      .lit_class  (lit_class)
   );

   // Scan state: advance with each processed character
   assign state_in = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= SCAN_RESET;
      else state_ff <= state_in;
   end

   nlc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && in_last_ff),
      .lit_class (lit_class),
      .can_load  (rsp_can_load),
      .rsp_if    (rsp_if)
   );

`ifndef NO_ASSERTIONS
   // A processed final character always produces a result
   assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_if.valid)
      else $error("final character processed without a result");

   // The word state is cleared after a final character
   assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.position == '0 && !state_ff.rejected &&
                                state_ff.mode == MODE_START)
      else $error("word state not cleared after final character");

   // A held character is never overwritten before it is processed
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff) && $stable(in_last_ff))
      else $error("input register overwritten while stalled");

   // Position saturates within a word
   assert property (@(posedge clock) disable iff (reset)
      advance && !in_last_ff && state_ff.position == POS_MAX |=> state_ff.position == POS_MAX)
      else $error("position did not saturate");

   // A rejected word stays rejected until its final character
   assert property (@(posedge clock) disable iff (reset)
      state_ff.rejected && !(advance && in_last_ff) |=> state_ff.rejected)
      else $error("rejected word recovered");
`endif

endmodule

// ===== tb/sv/tb_numeric_literal_classifier_core.sv =====
// Self-checking testbench for numeric_literal_classifier_core.
// Feeds words one character per transaction and checks each word's literal class
// against a built-in scan predictor. Depends on nlc_pkg, nlc_if and numeric_literal_classifier_core.
module tb_numeric_literal_classifier_core
   import nlc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_PERIOD   = 10;
   localparam int          RESET_CYCLES = 6;
   localparam int          WORD_ITEMS   = 1900;
   localparam int          TAIL_ITEMS   = 250;
   localparam int          DRAIN_CYCLES = 10;
   localparam int unsigned HOLD_START   = 1500;
   localparam int unsigned HOLD_LEN     = 300;
   localparam int unsigned CYCLE_LIMIT  = 200000;

   localparam string DEC_LEAD = "123456789";
   localparam string DEC_BODY = "0123456789_";
   localparam string DEC_DIGS = "0123456789";
   localparam string HEX_BODY = "0123456789ABCDEF_";
   localparam string BIN_BODY = "01_";
   localparam string OCT_BODY = "01234567_";
   localparam string SIGNS    = "+-";
   localparam string DEC_EXPS = "eE";
   localparam string HEX_EXPS = "pP";
   localparam string SOUP     = "0123456789ABCDEFabcdefxXpPeEb._+- ";

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              last_char;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nlc_req_if req_if ();
   nlc_rsp_if rsp_if ();

   numeric_literal_classifier_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   char_item_type     stim_q[$];
   logic [CHAR_W-1:0] word_buf[$];
   class_type         literal_class_q[$];

   int          fail_count  = 0;
   int          req_gap     = 0;
   int          rsp_gap     = 0;
   logic        quiet_tail  = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned hold_left   = 0;

   // Predictor state for the word being scanned
   logic [POS_W-1:0]  sc_pos;
   mode_type          sc_mode;
   logic [CHAR_W-1:0] sc_prev;
   logic              sc_exp;
   logic              sc_dot;
   logic              sc_sign;
   logic              sc_rej;

   // ---------------------------------------------------------------------
   // Scan predictor
   // ---------------------------------------------------------------------
   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_sign(input logic [CHAR_W-1:0] c);
      return c == CH_PLUS || c == CH_MINUS;
   endfunction

   function automatic logic is_octal_body(input logic [CHAR_W-1:0] c);
      return c == CH_UNDER || (c >= CH_ZERO && c <= CH_SEVEN);
   endfunction

   task automatic scan_clear();
      sc_pos  = '0;
      sc_mode = MODE_START;
      sc_prev = '0;
      sc_exp  = 1'b0;
      sc_dot  = 1'b0;
      sc_sign = 1'b0;
      sc_rej  = 1'b0;
   endtask

   // Decimal body: underscores are skipped and leave the sign window open
   task automatic take_dec(input logic [CHAR_W-1:0] c);
      if (c == CH_UNDER) begin
      end else if (sc_sign && is_sign(c)) begin
         sc_sign = 1'b0;
      end else begin
         sc_sign = 1'b0;
         if (c == CH_LO_E || c == CH_UP_E) begin
            if (sc_exp || sc_prev == CH_DOT) begin
               sc_rej = 1'b1;
            end else begin
               sc_sign = 1'b1;
               sc_dot  = 1'b1;
               sc_exp  = 1'b1;
            end
         end else if (c == CH_DOT) begin
            if (sc_dot || sc_exp) sc_rej = 1'b1;
            else sc_dot = 1'b1;
         end else if (!is_digit(c)) begin
            sc_rej = 1'b1;
         end
      end
   endtask

   // Hex body: dot and exponent mark count only after the first character past the prefix
   task automatic take_hex(input logic [CHAR_W-1:0] c);
      if (sc_sign && is_sign(c)) begin
         sc_sign = 1'b0;
      end else begin
         sc_sign = 1'b0;
         if (sc_pos == POS_MAX && (c == CH_LO_P || c == CH_UP_P) && !sc_exp
             && sc_prev != CH_DOT) begin
            sc_exp  = 1'b1;
            sc_dot  = 1'b1;
            sc_sign = 1'b1;
         end else if (sc_pos == POS_MAX && c == CH_DOT && !sc_dot) begin
            sc_dot = 1'b1;
         end else if (c != CH_UNDER && !(c >= CH_UP_A && c <= CH_UP_F) && !is_digit(c)) begin
            sc_rej = 1'b1;
         end
      end
   endtask

   function automatic class_type word_class(input logic [CHAR_W-1:0] c);
      if (sc_rej) return CLASS_INVALID;
      case (sc_mode)
         MODE_ZERO: return CLASS_INT;
         MODE_DEC: begin
            if (!is_digit(c) && c != CH_UNDER) return CLASS_INVALID;
            return sc_dot ? CLASS_DOUBLE : CLASS_INT;
         end
         MODE_HEX: begin
            if (sc_pos == POS_PREFIX) return CLASS_INVALID;
            if (sc_dot && !sc_exp) return CLASS_INVALID;
            return sc_dot ? CLASS_HEX_DOUBLE : CLASS_HEX_INT;
         end
         MODE_BIN: return (sc_pos == POS_PREFIX) ? CLASS_INVALID : CLASS_BINARY;
         MODE_OCT: return CLASS_OCTAL;
         default:  return CLASS_INVALID;
      endcase
   endfunction

   // Advance the word state by one character; queue the class on the last one
   task automatic scan_char(input logic [CHAR_W-1:0] c, input logic fin);
      if (!sc_rej) begin
         case (sc_mode)
            MODE_START: begin
               if (!is_digit(c)) sc_rej = 1'b1;
               else if (c == CH_ZERO) sc_mode = MODE_ZERO;
               else sc_mode = MODE_DEC;
            end
            MODE_ZERO: begin
               if (c == CH_DOT) begin
                  sc_mode = MODE_DEC;
                  take_dec(c);
               end else if (c == CH_LO_X) begin
                  sc_mode = MODE_HEX;
               end else if (c == CH_LO_B) begin
                  sc_mode = MODE_BIN;
               end else begin
                  sc_mode = MODE_OCT;
                  if (!is_octal_body(c)) sc_rej = 1'b1;
               end
            end
            MODE_DEC: take_dec(c);
            MODE_HEX: take_hex(c);
            MODE_BIN: begin
               if (c != CH_UNDER && c != CH_ZERO && c != CH_ONE) sc_rej = 1'b1;
            end
            MODE_OCT: begin
               if (!is_octal_body(c)) sc_rej = 1'b1;
            end
            default: sc_rej = 1'b1;
         endcase
      end
      if (fin) begin
         literal_class_q.push_back(word_class(c));
         scan_clear();
      end else begin
         sc_prev = c;
         if (sc_pos != POS_MAX) sc_pos = sc_pos + 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Word generation
   // ---------------------------------------------------------------------
   function automatic logic [CHAR_W-1:0] pick_from(input string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   task automatic put_char(input logic [CHAR_W-1:0] c);
      word_buf.push_back(c);
   endtask

   // Move the buffered word to the stimulus queue, last character flagged
   task automatic close_word();
      char_item_type item;
      while (word_buf.size() != 0) begin
         item.char_code = word_buf.pop_front();
         item.last_char = (word_buf.size() == 0);
         stim_q.push_back(item);
      end
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
      close_word();
   endtask

   // Mostly well-formed literals with random content, plus noise and damage
   task automatic gen_word();
      case ($urandom_range(0, 15))
         3, 4, 5: begin
            put_char(CH_ZERO);
            put_char(CH_LO_X);
            repeat ($urandom_range(0, 4)) put_char(pick_from(HEX_BODY));
            if ($urandom_range(0, 1)) begin
               put_char(CH_DOT);
               repeat ($urandom_range(0, 3)) put_char(pick_from(HEX_BODY));
            end
            if ($urandom_range(0, 2) != 0) begin
               put_char(pick_from(HEX_EXPS));
               if ($urandom_range(0, 1)) put_char(pick_from(SIGNS));
               repeat ($urandom_range(1, 3)) put_char(pick_from(DEC_BODY));
            end
         end
         6, 7: begin
            put_char(CH_ZERO);
            put_char(CH_LO_B);
            repeat ($urandom_range(0, 6)) put_char(pick_from(BIN_BODY));
         end
         8, 9: begin
            put_char(CH_ZERO);
            repeat ($urandom_range(1, 5)) put_char(pick_from(OCT_BODY));
         end
         10: put_char(CH_ZERO);
         11, 12: begin
            put_char(pick_from(DEC_DIGS));
            repeat ($urandom_range(0, 8)) put_char(pick_from(SOUP));
         end
         13: begin
            repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
         end
         default: begin
            if ($urandom_range(0, 4) == 0) begin
               put_char(CH_ZERO);
               put_char(CH_DOT);
            end else begin
               put_char(pick_from(DEC_LEAD));
            end
            repeat ($urandom_range(0, 3)) put_char(pick_from(DEC_BODY));
            if ($urandom_range(0, 1)) begin
               put_char(CH_DOT);
               repeat ($urandom_range(0, 3)) put_char(pick_from(DEC_BODY));
            end
            if ($urandom_range(0, 1)) begin
               put_char(pick_from(DEC_EXPS));
               if ($urandom_range(0, 1)) put_char(pick_from(SIGNS));
               repeat ($urandom_range(0, 3)) put_char(pick_from(DEC_BODY));
            end
            if ($urandom_range(0, 4) != 0) put_char(pick_from(DEC_DIGS));
         end
      endcase
      // damage one character now and then
      if ($urandom_range(0, 9) == 0) begin
         word_buf[$urandom_range(0, word_buf.size() - 1)] =
            $urandom_range(0, 1) ? pick_from(SOUP) : 8'($urandom_range(0, 255));
      end
      close_word();
   endtask

   // ---------------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      logic          offer;
      char_item_type item;
      if (reset) begin
         scan_clear();
         req_gap = 0;
         req_if.valid <= 1'b0;
         quiet_tail   <= 1'b0;
      end else begin
         // predict from the transaction taken at this edge
         if (req_if.valid && req_if.ready) scan_char(req_if.char_code, req_if.last_char);
         if (!req_if.valid || req_if.ready) begin
            offer = 1'b0;
            if (req_gap != 0) begin
               req_gap--;
            end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
               req_gap = $urandom_range(0, 14);
            end else if (stim_q.size() != 0) begin
               item  = stim_q.pop_front();
               offer = 1'b1;
            end
            req_if.valid <= offer;
            if (offer) begin
               req_if.char_code <= item.char_code;
               req_if.last_char <= item.last_char;
            end
         end
         quiet_tail <= (stim_q.size() < TAIL_ITEMS);
      end
   end

   // ---------------------------------------------------------------------
   // Long result hold-off, so the block fills and stalls its input
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (cycle_count == HOLD_START) begin
         hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor and ready control
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      logic      take;
      class_type want;
      if (reset) begin
         rsp_gap = 0;
         rsp_if.ready <= 1'b0;
      end else begin
         // check the transaction seen at this edge
         if (rsp_if.valid && rsp_if.ready) begin
            if (literal_class_q.size() == 0) begin
               $error("literal_class: expected none, actual %0d", rsp_if.literal_class);
               fail_count++;
            end else begin
               want = literal_class_q.pop_front();
               if (rsp_if.literal_class !== want) begin
                  $error("literal_class: expected %0d, actual %0d", want,
                         rsp_if.literal_class);
                  fail_count++;
               end
            end
         end
         take = 1'b1;
         if (rsp_gap != 0) begin
            rsp_gap--;
            take = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            rsp_gap = $urandom_range(0, 14);
            take    = 1'b0;
         end
         rsp_if.ready <= take && (hold_left == 0);
      end
   end

   // ---------------------------------------------------------------------
   // Cycle limit
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_numeric_literal_classifier_core: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid     = 1'b0;
      req_if.char_code = '0;
      req_if.last_char = 1'b0;
      rsp_if.ready     = 1'b0;

      // directed words: lone zero, octal, binary, bare hex prefix, lowercase
      // hex, exponent mark straight after the prefix, hex dot with no exponent,
      // hex exponent after a dot, underscore inside the sign window,
      // decimal exponent after a dot, and a byte above 127
      put_text("0");
      put_text("07");
      put_text("0b1");
      put_text("0x");
      put_text("0xa");
      put_text("0xp");
      put_text("0xF.");
      put_text("0xF.p");
      put_text("1e_+5");
      put_text("1.e");
      put_char(8'hFF);
      close_word();

      while (stim_q.size() < WORD_ITEMS) gen_word();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // hold until every character is taken and every class has come back
      do @(posedge clock);
      while (stim_q.size() != 0 || req_if.valid === 1'b1 || literal_class_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("tb_numeric_literal_classifier_core: PASS");
      end else begin
         $display("tb_numeric_literal_classifier_core: FAIL");
      end
      $finish;
   end

endmodule

// ===== numeric_literal_classifier_core.f =====
hw/rtl/nlc_pkg.sv
hw/rtl/nlc_if.sv
hw/rtl/nlc_scan.sv
hw/rtl/nlc_rsp_reg.sv
hw/rtl/numeric_literal_classifier_core.sv
tb/sv/tb_numeric_literal_classifier_core.sv
